### design/sbm_pkg.sv
package sbm_pkg;

  localparam int TABLE_BANDS    = 16;
  localparam int SAMPLE_RATE_HZ = 4000;
  localparam int TRACK_FIRST    = 4;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

  localparam logic [14:0] LEVEL_MAX = 15'd25600;
  // scaled difference at which the level reaches LEVEL_MAX (2048 * 25 / 2)
  localparam logic [24:0] SCALE_SAT = 25'd2048;
  localparam logic [8:0]  COEF_ONE  = 9'd256;
  localparam logic [6:0]  ROW_BASE  = 7'd80;
  localparam logic [6:0]  ROW_TOP   = 7'd13;
  localparam logic [6:0]  ROW_BOTTOM = 7'd79;
  // floor(li * 64 / 100) = (li * 16 * 1311) >> 15 for li up to 100
  localparam logic [21:0] BAR_RECIP = 22'd20976;
  localparam int          BAR_SHIFT = 15;
  // floor(pi * 67 / 100) = (pi * 67 * 5243) >> 19 for pi up to 100
  localparam logic [25:0] ROW_RECIP = 26'd351281;
  localparam int          ROW_SHIFT = 19;

  localparam logic [2:0] REG_NOISE_FLOOR = 3'd0;
  localparam logic [2:0] REG_LEVEL_GAIN  = 3'd1;
  localparam logic [2:0] REG_RISE_COEF   = 3'd2;
  localparam logic [2:0] REG_FALL_COEF   = 3'd3;
  localparam logic [2:0] REG_PEAK_DECAY  = 3'd4;

  localparam logic [6:0] BAND_EDGE [TABLE_BANDS+1] = '{
    7'd2, 7'd3, 7'd4, 7'd5, 7'd7, 7'd9, 7'd11, 7'd13, 7'd16,
    7'd19, 7'd23, 7'd28, 7'd34, 7'd41, 7'd49, 7'd58, 7'd64
  };

  typedef struct packed {
    logic [11:0] noise_floor;
    logic [6:0]  level_gain;
    logic [8:0]  rise_coef;
    logic [8:0]  fall_coef;
    logic [14:0] peak_decay;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  band;
    logic [17:0] band_max;
    logic [17:0] readout_mag;
    logic [10:0] readout_freq;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_flags_t;

endpackage

### design/sbm_front.sv
module sbm_front #(
  parameter int BAND_COUNT  = 16,
  parameter int FFT_POINTS  = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [5:0]         in_bin_index,
  input  logic [17:0]        in_bin_magnitude,
  input  logic               in_readout_due,
  input  sbm_pkg::queue_flags_t q_flags,
  output logic               q_push,
  output sbm_pkg::job_t      q_job
);

  localparam int NB = (BAND_COUNT < sbm_pkg::TABLE_BANDS) ? BAND_COUNT : sbm_pkg::TABLE_BANDS;
  localparam int FRAME_LAST  = FFT_POINTS / 2 - 1;
  localparam int HZ_PER_BIN  = sbm_pkg::SAMPLE_RATE_HZ / FFT_POINTS;

  logic [17:0] rmax_r, rmax_nxt;
  logic [17:0] fmax_r, fmax_nxt;
  logic [5:0]  fbin_r, fbin_nxt;
  logic [17:0] lmag_r, lmag_nxt;
  logic [10:0] lfreq_r, lfreq_nxt;

  logic        accept;
  logic        in_band, band_first, band_last;
  logic [3:0]  band_idx;
  logic        track;
  logic        frame_end;
  logic [17:0] fmax_new;
  logic [5:0]  fbin_new;

  assign in_stall = q_flags.full;
  assign accept   = in_valid && !in_stall;

  // band lookup over the edge table
  always_comb begin
    in_band    = 1'b0;
    band_first = 1'b0;
    band_last  = 1'b0;
    band_idx   = '0;
    for (int k = 0; k < NB; k++) begin
      if ({1'b0, in_bin_index} >= sbm_pkg::BAND_EDGE[k] &&
          {1'b0, in_bin_index} < sbm_pkg::BAND_EDGE[k+1]) begin
        in_band    = 1'b1;
        band_idx   = 4'(k);
        band_first = ({1'b0, in_bin_index} == sbm_pkg::BAND_EDGE[k]);
        band_last  = ({1'b0, in_bin_index} == sbm_pkg::BAND_EDGE[k+1] - 7'd1);
      end
    end
  end

  always_comb begin
    track     = (int'(in_bin_index) >= sbm_pkg::TRACK_FIRST) &&
                (int'(in_bin_index) <= FRAME_LAST) && (in_bin_magnitude > fmax_r);
    frame_end = (int'(in_bin_index) == FRAME_LAST);
    fmax_new  = track ? in_bin_magnitude : fmax_r;
    fbin_new  = track ? in_bin_index : fbin_r;

    fmax_nxt  = fmax_new;
    fbin_nxt  = fbin_new;
    lmag_nxt  = lmag_r;
    lfreq_nxt = lfreq_r;
    if (frame_end) begin
      if (in_readout_due) begin
        lmag_nxt  = fmax_new;
        lfreq_nxt = 11'(13'(fbin_new) * 13'(HZ_PER_BIN));
      end
      fmax_nxt = '0;
      fbin_nxt = '0;
    end

    rmax_nxt = rmax_r;
    if (in_band) begin
      if (band_first || in_bin_magnitude > rmax_r) begin
        rmax_nxt = in_bin_magnitude;
      end
    end
  end

  assign q_push              = accept && in_band && band_last;
  assign q_job.band          = band_idx;
  assign q_job.band_max      = rmax_nxt;
  assign q_job.readout_mag   = lmag_nxt;
  assign q_job.readout_freq  = lfreq_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rmax_r  <= '0;
      fmax_r  <= '0;
      fbin_r  <= '0;
      lmag_r  <= '0;
      lfreq_r <= '0;
    end else if (accept) begin
      rmax_r  <= rmax_nxt;
      fmax_r  <= fmax_nxt;
      fbin_r  <= fbin_nxt;
      lmag_r  <= lmag_nxt;
      lfreq_r <= lfreq_nxt;
    end
  end

endmodule

### design/sbm_queue.sv
module sbm_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  sbm_pkg::job_t         push_job,
  input  logic                  pop,
  output sbm_pkg::job_t         head_job,
  output sbm_pkg::queue_flags_t flags
);

  localparam int PTR_W = sbm_pkg::QPTR_W;
  localparam int CNT_W = sbm_pkg::QPTR_W + 1;

  sbm_pkg::job_t slot_r [sbm_pkg::QUEUE_DEPTH];
  logic [sbm_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]           count_r, count_nxt;

  assign flags.full  = (count_r == CNT_W'(sbm_pkg::QUEUE_DEPTH));
  assign flags.empty = (count_r == '0);
  assign head_job    = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !flags.full)
    else $error("queue pushed while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !flags.empty)
    else $error("queue popped while empty");
`endif

endmodule

### design/sbm_back.sv
module sbm_back #(
  parameter int ROWS_PER_BLOCK = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sbm_pkg::cfg_t         cfg,
  input  sbm_pkg::job_t         head_job,
  input  sbm_pkg::queue_flags_t q_flags,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [3:0]            out_band_number,
  output logic [14:0]           out_band_level,
  output logic [3:0]            out_block_count,
  output logic [6:0]            out_peak_row,
  output logic [17:0]           out_readout_magnitude,
  output logic [10:0]           out_readout_freq_hz
);

  localparam int          DIV_SHIFT = 12;
  localparam logic [19:0] DIV_RECIP =
    20'(((1 << DIV_SHIFT) + ROWS_PER_BLOCK - 1) / ROWS_PER_BLOCK);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCALE = 8'b0000_0010,
    S_RAW   = 8'b0000_0100,
    S_MIXA  = 8'b0000_1000,
    S_MIXB  = 8'b0001_0000,
    S_PEAK  = 8'b0010_0000,
    S_ROWS  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } back_state_t;

  back_state_t state_r, state_nxt;

  logic [14:0] lvl_mem [sbm_pkg::TABLE_BANDS];
  logic [14:0] pk_mem  [sbm_pkg::TABLE_BANDS];
  logic [sbm_pkg::TABLE_BANDS-1:0] written_r;

  sbm_pkg::job_t job_r;
  logic [14:0] old_lvl_r, old_pk_r;
  logic        old_ok_r;
  logic [24:0] p1_r;
  logic [14:0] raw_r;
  logic [8:0]  coef_r;
  logic [23:0] acc_r;
  logic [14:0] lvl_r, pk_r;
  logic [6:0]  bq_r;
  logic [3:0]  blocks_r;
  logic [6:0]  row_r;

  logic        out_valid_r;
  logic [3:0]  out_band_r;
  logic [14:0] out_level_r;
  logic [3:0]  out_blocks_r;
  logic [6:0]  out_row_r;
  logic [17:0] out_rmag_r;
  logic [10:0] out_rfreq_r;

  logic [14:0] old_lvl, old_pk;
  logic [17:0] diff;
  logic [8:0]  coef_sel, coef_cap;
  logic [24:0] mix_sum;
  logic [16:0] lvl_full;
  logic [14:0] pk_new;
  logic [21:0] bar_prod;
  logic [19:0] blk_prod;
  logic [25:0] row_prod;
  logic [6:0]  row_off, row_raw;
  logic        out_load;

  assign old_lvl = old_ok_r ? old_lvl_r : '0;
  assign old_pk  = old_ok_r ? old_pk_r  : '0;
  assign q_pop    = (state_r == S_IDLE) && !q_flags.empty;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    diff     = (job_r.band_max > {6'd0, cfg.noise_floor}) ?
               job_r.band_max - {6'd0, cfg.noise_floor} : '0;
    coef_sel = (raw_r > old_lvl) ? cfg.rise_coef : cfg.fall_coef;
    coef_cap = (coef_sel > sbm_pkg::COEF_ONE) ? sbm_pkg::COEF_ONE : coef_sel;
    mix_sum  = 25'(acc_r) + 25'(24'(old_lvl) * 24'(sbm_pkg::COEF_ONE - coef_r)) + 25'd128;
    lvl_full = mix_sum[24:8];
    if (old_pk > cfg.peak_decay) begin
      pk_new = old_pk - cfg.peak_decay;
    end else begin
      pk_new = '0;
    end
    if (lvl_r > old_pk) begin
      pk_new = lvl_r;
    end
    bar_prod = 22'(lvl_r[14:8]) * sbm_pkg::BAR_RECIP;
    blk_prod = 20'(bq_r) * DIV_RECIP;
    row_prod = 26'(pk_r[14:8]) * sbm_pkg::ROW_RECIP;
    row_off  = 7'(row_prod >> sbm_pkg::ROW_SHIFT);
    row_raw  = (row_off >= sbm_pkg::ROW_BASE) ? '0 : sbm_pkg::ROW_BASE - row_off;
    if (row_raw < sbm_pkg::ROW_TOP) begin
      row_raw = sbm_pkg::ROW_TOP;
    end else if (row_raw > sbm_pkg::ROW_BOTTOM) begin
      row_raw = sbm_pkg::ROW_BOTTOM;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (!q_flags.empty) state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_RAW;
      S_RAW:   state_nxt = S_MIXA;
      S_MIXA:  state_nxt = S_MIXB;
      S_MIXB:  state_nxt = S_PEAK;
      S_PEAK:  state_nxt = S_ROWS;
      S_ROWS:  state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      written_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_ROWS) written_r[job_r.band] <= 1'b1;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // band state stores, read at dequeue, written back once the level settles
  always_ff @(posedge clk) begin
    if (q_pop) begin
      old_lvl_r <= lvl_mem[head_job.band];
      old_pk_r  <= pk_mem[head_job.band];
    end
    if (state_r == S_ROWS) begin
      lvl_mem[job_r.band] <= lvl_r;
      pk_mem[job_r.band]  <= pk_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r    <= head_job;
      old_ok_r <= written_r[head_job.band];
    end
    if (state_r == S_SCALE) p1_r <= 25'(diff) * 25'(cfg.level_gain);
    if (state_r == S_RAW) begin
      raw_r <= (p1_r > sbm_pkg::SCALE_SAT) ? sbm_pkg::LEVEL_MAX :
               15'((16'(p1_r[11:0]) * 16'd25) >> 1);
    end
    if (state_r == S_MIXA) begin
      coef_r <= coef_cap;
      acc_r  <= 24'(raw_r) * 24'(coef_cap);
    end
    if (state_r == S_MIXB) begin
      lvl_r <= (lvl_full > 17'(sbm_pkg::LEVEL_MAX)) ? sbm_pkg::LEVEL_MAX : lvl_full[14:0];
    end
    if (state_r == S_PEAK) begin
      pk_r <= pk_new;
      bq_r <= 7'(bar_prod >> sbm_pkg::BAR_SHIFT);
    end
    if (state_r == S_ROWS) begin
      blocks_r <= 4'(blk_prod >> DIV_SHIFT);
      row_r    <= row_raw;
    end
    if (out_load) begin
      out_band_r   <= job_r.band;
      out_level_r  <= lvl_r;
      out_blocks_r <= blocks_r;
      out_row_r    <= row_r;
      out_rmag_r   <= job_r.readout_mag;
      out_rfreq_r  <= job_r.readout_freq;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_band_number       = out_band_r;
  assign out_band_level        = out_level_r;
  assign out_block_count       = out_blocks_r;
  assign out_peak_row          = out_row_r;
  assign out_readout_magnitude = out_rmag_r;
  assign out_readout_freq_hz   = out_rfreq_r;

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_level_r <= sbm_pkg::LEVEL_MAX)
    else $error("band level above full scale");
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_row_r >= sbm_pkg::ROW_TOP && out_row_r <= sbm_pkg::ROW_BOTTOM))
    else $error("peak row outside screen range");
  a_done_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> ($past(state_r) == S_ROWS || $past(state_r) == S_DONE))
    else $error("result stage entered without store write back");
`endif

endmodule

### design/spectrum_band_meter_top.sv
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+------------------------------------------
// in_      | input     | in_valid / in_stall  | bin_index, bin_magnitude, readout_due
// out_     | output    | out_valid / out_stall| band_number, band_level, block_count,
//          |           |                      | peak_row, readout_magnitude, readout_freq_hz
// cfg_     | input     | cfg_valid / cfg_ready| cfg_index (register), cfg_data
//
// The front end takes one bin per cycle while the job queue has room; only a band's
// last bin enqueues work. The back end's shared sequencer takes one band at a time
// through dequeue, scale, raw level, two smoothing multiplies, peak, bar/row and result.
// Reset is synchronous, active low; band stores read as zero until first written.
// in_stall rises only when the 4-entry queue is full; out_stall holds the result register
// and, once that is full, the back end waits in its result state.
module spectrum_band_meter_top #(
  parameter int BAND_COUNT     = 16,
  parameter int FFT_POINTS     = 128,
  parameter int ROWS_PER_BLOCK = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  in_bin_index,
  input  logic [17:0] in_bin_magnitude,
  input  logic        in_readout_due,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_band_number,
  output logic [14:0] out_band_level,
  output logic [3:0]  out_block_count,
  output logic [6:0]  out_peak_row,
  output logic [17:0] out_readout_magnitude,
  output logic [10:0] out_readout_freq_hz,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  sbm_pkg::cfg_t         cfg_r;
  sbm_pkg::job_t         push_job, head_job;
  sbm_pkg::queue_flags_t q_flags;
  logic                  q_push, q_pop;

  // every configuration transfer completes at once
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.noise_floor <= 12'd30;
      cfg_r.level_gain  <= 7'd8;
      cfg_r.rise_coef   <= 9'd230;
      cfg_r.fall_coef   <= 9'd77;
      cfg_r.peak_decay  <= 15'd512;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sbm_pkg::REG_NOISE_FLOOR: cfg_r.noise_floor <= cfg_data[11:0];
        sbm_pkg::REG_LEVEL_GAIN:  cfg_r.level_gain  <= cfg_data[6:0];
        sbm_pkg::REG_RISE_COEF:   cfg_r.rise_coef   <= cfg_data[8:0];
        sbm_pkg::REG_FALL_COEF:   cfg_r.fall_coef   <= cfg_data[8:0];
        sbm_pkg::REG_PEAK_DECAY:  cfg_r.peak_decay  <= cfg_data[14:0];
        default: ; // drop writes to unmapped indexes
      endcase
    end
  end

  // front: band classification, running maxima, loudest-bin readout latch
  sbm_front #(
    .BAND_COUNT (BAND_COUNT),
    .FFT_POINTS (FFT_POINTS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_bin_index     (in_bin_index),
    .in_bin_magnitude (in_bin_magnitude),
    .in_readout_due   (in_readout_due),
    .q_flags          (q_flags),
    .q_push           (q_push),
    .q_job            (push_job)
  );

  // hold finished band maxima between the two halves
  sbm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .flags    (q_flags)
  );

  // back: level, smoothing, peak hold, bar and row, result register
  sbm_back #(
    .ROWS_PER_BLOCK (ROWS_PER_BLOCK)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg_r),
    .head_job              (head_job),
    .q_flags               (q_flags),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_band_number       (out_band_number),
    .out_band_level        (out_band_level),
    .out_block_count       (out_block_count),
    .out_peak_row          (out_peak_row),
    .out_readout_magnitude (out_readout_magnitude),
    .out_readout_freq_hz   (out_readout_freq_hz)
  );

endmodule
